>>> hw/rtl/rtcssd_pkg.sv
// ----------------------------------------------------------------------------
// rtcssd_pkg
// shared types and constants of the rtc seven-segment scan driver
// ----------------------------------------------------------------------------
package rtcssd_pkg;

  localparam int DIGIT_COUNT  = 8;
  localparam int STORE_DEPTH  = 8;
  localparam int SHOWN_DIGITS = 6;
  localparam int POS_W        = $clog2(STORE_DEPTH);
  localparam int INTERVAL_W   = 10;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(100);

  localparam logic CMD_TICK     = 1'b0;
  localparam logic CMD_SNAPSHOT = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic       show_time;
    logic [7:0] sec_bcd;
    logic [7:0] min_bcd;
    logic [7:0] hour_bcd;
    logic [7:0] date_bcd;
    logic [7:0] month_bcd;
    logic [7:0] year_bcd;
  } in_item_t;

  typedef struct packed {
    logic [7:0] segments;
    logic [7:0] digit_select;
    logic       read_request;
  } out_item_t;

  typedef logic [7:0] pattern_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             read_request;
  } scan_status_t;

endpackage

>>> hw/rtl/rtcssd_decode.sv
// ----------------------------------------------------------------------------
// rtcssd_decode
// turns a clock snapshot into the six digit patterns of the display
// ----------------------------------------------------------------------------
module rtcssd_decode (
  input  rtcssd_pkg::in_item_t item,
  output rtcssd_pkg::pattern_t patterns [rtcssd_pkg::SHOWN_DIGITS]
);
  import rtcssd_pkg::*;

  function automatic logic [6:0] bcd_value(input logic [7:0] raw, input logic [7:0] mask);
    logic [7:0] masked;
    logic [7:0] v;
    masked = raw & mask;
    v = 8'(masked[7:4]) * 8'd10 + 8'(raw[3:0]);
    bcd_value = (v > 8'd99) ? 7'd99 : v[6:0];
  endfunction

  function automatic logic [6:0] glyph(input logic [3:0] d);
    unique case (d)
      4'd0:    glyph = 7'b0111111;
      4'd1:    glyph = 7'b0000110;
      4'd2:    glyph = 7'b1011011;
      4'd3:    glyph = 7'b1001111;
      4'd4:    glyph = 7'b1100110;
      4'd5:    glyph = 7'b1101101;
      4'd6:    glyph = 7'b1111101;
      4'd7:    glyph = 7'b0000111;
      4'd8:    glyph = 7'b1111111;
      4'd9:    glyph = 7'b1101111;
      default: glyph = 7'b0000000;
    endcase
  endfunction

  logic [6:0]  vals  [3];
  logic [14:0] prod  [3];
  logic [3:0]  tens  [3];
  logic [6:0]  units [3];

  always_comb begin
    if (item.show_time) begin
      vals[0] = bcd_value(item.hour_bcd, 8'hF0);
      vals[1] = bcd_value(item.min_bcd, 8'hF0);
      vals[2] = bcd_value(item.sec_bcd, 8'hF0);
    end else begin
      vals[0] = bcd_value(item.date_bcd, 8'hF0);
      vals[1] = bcd_value(item.month_bcd, 8'h70);
      vals[2] = bcd_value(item.year_bcd, 8'hF0);
    end
    for (int i = 0; i < 3; i++) begin
      // divide by ten through the reciprocal 205/2048, exact below 1029
      prod[i]  = 15'(vals[i]) * 15'd205;
      tens[i]  = prod[i][14:11];
      units[i] = vals[i] - 7'(tens[i]) * 7'd10;
      patterns[2*i]   = {1'b0, glyph(tens[i])};
      patterns[2*i+1] = {1'b1, glyph(units[i][3:0])};
    end
  end

endmodule

>>> hw/rtl/rtcssd_scan.sv
// ----------------------------------------------------------------------------
// rtcssd_scan
// scan position and read request counter, advanced once per tick
// ----------------------------------------------------------------------------
module rtcssd_scan (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                tick,
  input  logic [rtcssd_pkg::INTERVAL_W-1:0]   read_interval,
  output rtcssd_pkg::scan_status_t            status
);
  import rtcssd_pkg::*;

  localparam logic [POS_W:0] POS_LIMIT = (POS_W+1)'(DIGIT_COUNT);

  logic [POS_W-1:0]      pos;
  logic [POS_W-1:0]      pos_next;
  logic [POS_W:0]        pos_inc;
  logic [INTERVAL_W-1:0] tick_count;
  logic [INTERVAL_W-1:0] tick_count_next;
  logic [INTERVAL_W-1:0] count_inc;
  logic [INTERVAL_W-1:0] limit;
  logic                  hit;

  always_comb begin
    limit     = (read_interval == '0) ? INTERVAL_W'(1) : read_interval;
    count_inc = tick_count + INTERVAL_W'(1);
    hit       = count_inc >= limit;
    tick_count_next = hit ? '0 : count_inc;
    pos_inc   = {1'b0, pos} + (POS_W+1)'(1);
    pos_next  = (pos_inc >= POS_LIMIT) ? '0 : pos_inc[POS_W-1:0];
    status.pos          = pos;
    status.read_request = hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      tick_count <= '0;
    end else if (tick) begin
      pos        <= pos_next;
      tick_count <= tick_count_next;
    end
  end

endmodule

>>> hw/rtl/rtc_seven_segment_scan_driver_core.sv
// ----------------------------------------------------------------------------
// rtc_seven_segment_scan_driver_core
// multiplexed seven-segment driver fed by real-time-clock snapshots
// ----------------------------------------------------------------------------
// Takes one item per cycle unless rsp_stall holds the output. A snapshot
// refreshes the six-digit display store (time or date, dot on odd positions,
// last two positions blank) and gives no transfer out. A tick gives one
// transfer out via the input and result registers: the segment byte and the
// active-low digit select of the current position, plus read_request every
// read_interval ticks. Store and counters update between those registers.
// User must write read_interval via cfg_write only while idle; not enforced.
module rtc_seven_segment_scan_driver_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  rtcssd_pkg::in_item_t                req_data,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output rtcssd_pkg::out_item_t               rsp_data,
  input  logic                                cfg_write,
  input  logic [rtcssd_pkg::INTERVAL_W-1:0]   cfg_data
);
  import rtcssd_pkg::*;

  logic [INTERVAL_W-1:0] read_interval;
  logic                  stage_valid;
  in_item_t              stage_item;
  logic                  advance;
  logic                  fire;
  logic                  tick;
  logic                  snap;
  pattern_t              store [SHOWN_DIGITS];
  pattern_t              decoded [SHOWN_DIGITS];
  pattern_t              read_pattern;
  scan_status_t          status;

  assign advance   = !rsp_valid || !rsp_stall;
  assign req_stall = stage_valid && !advance;
  assign fire      = stage_valid && advance;
  assign tick      = fire && (stage_item.cmd == CMD_TICK);
  assign snap      = fire && (stage_item.cmd == CMD_SNAPSHOT);

  always_ff @(posedge clk) begin
    if (rst) begin
      read_interval <= INTERVAL_RESET;
    end else if (cfg_write) begin
      read_interval <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!req_stall) begin
      stage_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall) begin
      stage_item <= req_data;
    end
  end

  rtcssd_decode u_decode (
    .item     (stage_item),
    .patterns (decoded)
  );

  rtcssd_scan u_scan (
    .clk           (clk),
    .rst           (rst),
    .tick          (tick),
    .read_interval (read_interval),
    .status        (status)
  );

  // display store
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SHOWN_DIGITS; i++) begin
        store[i] <= '0;
      end
    end else if (snap) begin
      for (int i = 0; i < SHOWN_DIGITS; i++) begin
        store[i] <= decoded[i];
      end
    end
  end

  always_comb begin
    read_pattern = '0;
    for (int i = 0; i < SHOWN_DIGITS; i++) begin
      if (status.pos == POS_W'(i)) begin
        read_pattern = store[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= tick;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      rsp_data.segments     <= read_pattern;
      rsp_data.digit_select <= ~(8'd1 << status.pos);
      rsp_data.read_request <= status.read_request;
    end
  end

  a_one_cold_select : assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> $countones(~rsp_data.digit_select) == 1)
    else $error("digit select is not one-cold");

  a_tick_gives_result : assert property (@(posedge clk) disable iff (rst)
    tick |=> rsp_valid)
    else $error("tick produced no transfer");

  a_snapshot_silent : assert property (@(posedge clk) disable iff (rst)
    snap |=> !rsp_valid)
    else $error("snapshot produced a transfer");

  a_pos_in_range : assert property (@(posedge clk) disable iff (rst)
    32'(status.pos) < DIGIT_COUNT)
    else $error("scan position out of range");

endmodule
